// ----- hw/rtl/fcst_pkg.sv -----
package fcst_pkg;

    localparam int RING_SIZE = 16;
    localparam int PIX_W     = 8;
    localparam int HALF_W    = 64;
    localparam int THR_W     = 8;
    localparam int ARC_W     = 5;
    localparam int SCORE_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARC_LENGTH = 2'd1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET  = 8'd20;
    localparam logic [ARC_W-1:0] ARC_LENGTH_RESET = 5'd12;

    typedef logic [RING_SIZE-1:0] ring_mask_t;

    // Per-pixel classification of one candidate, one bit per ring position
    typedef struct packed {
        ring_mask_t bright;
        ring_mask_t dark;
    } class_t;

    typedef struct packed {
        logic               is_corner;
        logic               arc_polarity;
        logic [SCORE_W-1:0] score;
    } result_t;

endpackage

// ----- hw/rtl/fcst_if.sv -----
interface fcst_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [fcst_pkg::PIX_W-1:0]     center_pixel;
    logic [fcst_pkg::HALF_W-1:0]    ring_first_half;
    logic [fcst_pkg::HALF_W-1:0]    ring_second_half;

    modport source (output valid, center_pixel, ring_first_half, ring_second_half,
                    input ready);
    modport sink   (input valid, center_pixel, ring_first_half, ring_second_half,
                    output ready);
endinterface

interface fcst_result_if;
    logic                           valid;
    logic                           ready;
    logic                           is_corner;
    logic                           arc_polarity;
    logic [fcst_pkg::SCORE_W-1:0]   score;

    modport source (output valid, is_corner, arc_polarity, score, input ready);
    modport sink   (input valid, is_corner, arc_polarity, score, output ready);
endinterface

interface fcst_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fcst_pkg::CFG_IDX_W-1:0]    index;
    logic [fcst_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/fcst_lane.sv -----
module fcst_lane (
    input  logic                       clk,
    input  logic                       en,
    input  logic [fcst_pkg::PIX_W-1:0] center,
    input  logic [fcst_pkg::PIX_W-1:0] pixel,
    input  logic [fcst_pkg::THR_W-1:0] thr,
    output logic                       bright,
    output logic                       dark
);
    import fcst_pkg::*;

    // One extra bit keeps center + thr and pixel + thr exact
    logic [PIX_W:0] center_hi;
    logic [PIX_W:0] pixel_hi;
    logic           bright_next;
    logic           dark_next;
    logic           bright_reg;
    logic           dark_reg;

    always_comb
    begin
        center_hi   = {1'b0, center} + {1'b0, thr};
        pixel_hi    = {1'b0, pixel} + {1'b0, thr};
        bright_next = {1'b0, pixel} > center_hi;
        // pixel < center - thr, rewritten to avoid a negative bound
        dark_next   = pixel_hi < {1'b0, center};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bright_reg <= bright_next;
            dark_reg   <= dark_next;
        end
    end

    assign bright = bright_reg;
    assign dark   = dark_reg;

endmodule

// ----- hw/rtl/fcst_merge.sv -----
module fcst_merge (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  fcst_pkg::class_t           cls,
    input  logic [fcst_pkg::ARC_W-1:0] arc_length,
    fcst_result_if.source              result
);
    import fcst_pkg::*;

    logic [ARC_W-1:0]       need;
    logic                   too_long;
    ring_mask_t             win;
    logic [2*RING_SIZE-1:0] dbl_b;
    logic [2*RING_SIZE-1:0] dbl_d;
    ring_mask_t             hit_b;
    ring_mask_t             hit_d;
    ring_mask_t             classed;
    logic                   bright_ok;
    logic                   dark_ok;
    logic [SCORE_W-1:0]     count;
    logic                   ovalid_reg;
    logic                   ovalid_next;
    result_t                res_reg;
    result_t                res_next;
    logic                   take;

    always_comb
    begin
        need     = (arc_length == '0) ? ARC_W'(1) : arc_length;
        too_long = arc_length > ARC_W'(RING_SIZE);
        win      = RING_SIZE'(({{RING_SIZE{1'b0}}, 1'b1} << need) - (RING_SIZE + 1)'(1));
        dbl_b    = {cls.bright, cls.bright};
        dbl_d    = {cls.dark, cls.dark};
        // Window check at every start position on the ring, wrap included
        for (int s = 0; s < RING_SIZE; s++)
        begin
            hit_b[s] = &(dbl_b[s +: RING_SIZE] | ~win);
            hit_d[s] = &(dbl_d[s +: RING_SIZE] | ~win);
        end
        bright_ok = !too_long && (|hit_b);
        dark_ok   = !too_long && (|hit_d);
        classed   = cls.bright | cls.dark;
        count     = '0;
        for (int k = 0; k < RING_SIZE; k++)
        begin
            count = count + SCORE_W'(classed[k]);
        end
        res_next.is_corner    = bright_ok || dark_ok;
        res_next.arc_polarity = bright_ok;
        res_next.score        = count;
    end

    assign in_ready    = !ovalid_reg || result.ready;
    assign take        = in_valid && in_ready;
    assign ovalid_next = take ? 1'b1 : (result.ready ? 1'b0 : ovalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid        = ovalid_reg;
    assign result.is_corner    = res_reg.is_corner;
    assign result.arc_polarity = res_reg.arc_polarity;
    assign result.score        = res_reg.score;

    a_pol_needs_corner: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !res_reg.is_corner |-> !res_reg.arc_polarity)
        else $error("polarity set without corner");

    a_corner_has_score: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && res_reg.is_corner |-> res_reg.score != '0)
        else $error("corner with zero score");

    a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
        take && cls.bright == '0 && cls.dark == '0 |=> !res_reg.is_corner)
        else $error("corner from unclassed ring");

endmodule

// ----- hw/rtl/fast_corner_segment_test.sv -----
// Segment-test corner classifier, one candidate pixel per request.
//
// pixel  : input requests carry center_pixel and the 16 ring intensities,
//          packed eight to a word in circular order.
// result : one response per request with is_corner, arc_polarity (1 bright,
//          0 dark, bright wins a tie) and score (count of classed ring pixels).
// cfg    : register writes, index 0 intensity_threshold, index 1 arc_length;
//          cfg.ready is always high. Write only while the block is idle.
//
// A request passes two register stages, lane registers then merge output
// register, before its result shows on result.valid. Throughput: one request
// per cycle while result.ready is high, set by sixteen classifier lanes in
// stage one and the window/popcount merge in stage two, both fully parallel.
// Stalls: the output register holds its result while result.ready is low;
// stage one keeps filling, so pixel.ready drops only once both stages hold
// a result, and rises again the cycle the receiver takes one.
// Reset: pipeline emptied, threshold back to 20, arc length back to 12.
module fast_corner_segment_test (
    input  logic         clk,
    input  logic         rst_n,
    fcst_pixel_if.sink   pixel,
    fcst_result_if.source result,
    fcst_cfg_if.sink     cfg
);
    import fcst_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic [ARC_W-1:0] arc_reg;
    logic             valid1_reg;
    logic             valid1_next;
    logic             merge_ready;
    logic             take;
    class_t           cls;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
            arc_reg <= ARC_LENGTH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_THRESHOLD:  thr_reg <= cfg.data[THR_W-1:0];
                CFG_ARC_LENGTH: arc_reg <= cfg.data[ARC_W-1:0];
                default:        ;
            endcase
        end
    end

    // Stage one: classifier lanes, one per ring position
    assign pixel.ready = !valid1_reg || merge_ready;
    assign take        = pixel.valid && pixel.ready;
    assign valid1_next = pixel.ready ? pixel.valid : valid1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= valid1_next;
        end
    end

    for (genvar k = 0; k < RING_SIZE; k++)
    begin : g_lane
        localparam int LO = (k % (RING_SIZE / 2)) * PIX_W;
        logic [PIX_W-1:0] ring_px;

        if (k < RING_SIZE / 2)
        begin : g_first
            assign ring_px = pixel.ring_first_half[LO +: PIX_W];
        end
        else
        begin : g_second
            assign ring_px = pixel.ring_second_half[LO +: PIX_W];
        end

        fcst_lane u_lane (
            .clk    (clk),
            .en     (take),
            .center (pixel.center_pixel),
            .pixel  (ring_px),
            .thr    (thr_reg),
            .bright (cls.bright[k]),
            .dark   (cls.dark[k])
        );
    end

    // Stage two: arc search, score and output register
    fcst_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (valid1_reg),
        .in_ready   (merge_ready),
        .cls        (cls),
        .arc_length (arc_reg),
        .result     (result)
    );

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid1_reg && !merge_ready |=> valid1_reg && $stable(cls))
        else $error("stage one lost a held request");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        valid1_reg && result.valid && !result.ready |-> !pixel.ready)
        else $error("accepted with both stages full");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid1_reg |-> pixel.ready)
        else $error("stage one empty but not ready");

endmodule
